// ----- design/nfs_pkg.sv -----
// Shared widths and types for the non-preemptive FCFS/SJF scheduler.
`default_nettype none
package nfs_pkg;
  localparam int unsigned MaxProcsDef = 64;
  localparam int unsigned TimeW = 16;
  localparam int unsigned TickW = 24;
  localparam int unsigned SumW = 30;
  localparam int unsigned PidxW = 6;
  localparam int unsigned DivNumW = SumW + 8;
  localparam int unsigned InDataW = 32;
  localparam int unsigned OutDataW = 152;
  localparam logic [TickW-1:0] TickMax = '1;
  localparam logic PolicyFcfs = 1'b0;

  typedef enum logic [6:0] {
    StLoad = 7'b0000001,
    StScan = 7'b0000010,
    StCalc = 7'b0000100,
    StDivW = 7'b0001000,
    StDivT = 7'b0010000,
    StDivA = 7'b0100000,
    StEmit = 7'b1000000
  } sched_state_e;

  typedef struct packed {
    logic [TimeW-1:0] arr;
    logic [TimeW-1:0] svc;
  } proc_entry_t;
endpackage
`default_nettype wire

// ----- design/nfs_store.sv -----
// Process table memory: one write port, one registered read port.
`default_nettype none
module nfs_store
  import nfs_pkg::*;
#(
  parameter int unsigned Depth = MaxProcsDef,
  parameter int unsigned AddrW = 6
) (
  input  wire logic        clk_i,
  input  wire logic        we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire proc_entry_t wdata_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output proc_entry_t      rdata_o
);
  proc_entry_t mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

// ----- design/nfs_div.sv -----
// Restoring divider, one quotient bit per cycle, quotient saturated to 24 bits.
`default_nettype none
module nfs_div
  import nfs_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic [DivNumW-1:0] num_i,
  input  wire logic [TimeW-1:0]   den_i,
  output logic                    done_o,
  output logic [TickW-1:0]        quot_o
);
  localparam int unsigned CntW = $clog2(DivNumW);

  logic               busy_q;
  logic [CntW-1:0]    cnt_q;
  logic [TimeW-1:0]   rem_q;
  logic [TimeW-1:0]   den_q;
  logic [DivNumW-1:0] quo_q;
  logic               done_q;
  logic [TimeW:0]     trial;
  logic               qbit;

  always_comb begin
    trial = {rem_q, quo_q[DivNumW-1]};
    qbit  = (trial >= {1'b0, den_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntW'(DivNumW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      den_q <= den_i;
      quo_q <= num_i;
    end else if (busy_q) begin
      rem_q <= qbit ? TimeW'(trial - {1'b0, den_q}) : trial[TimeW-1:0];
      quo_q <= {quo_q[DivNumW-2:0], qbit};
    end
  end

  assign done_o = done_q;
  assign quot_o = (|quo_q[DivNumW-1:TickW]) ? TickMax : quo_q[TickW-1:0];
endmodule
`default_nettype wire

// ----- design/nonpreemptive_fcfs_sjf_scheduler.sv -----
// Non-preemptive FCFS / SJF scheduler: table load, scan, dispatch and statistics.
// Usage: processes arrive on the slave stream, one beat each, tdata holding the
// arrival tick (low 16 bits) and service ticks (next 16); tlast marks the final
// process and starts the schedule. Beats beyond MAX_PROCS are dropped.
// cfg_we_i writes policy_mode (0 FCFS, 1 SJF); the user must write it only while
// the block is idle, which the block itself leaves unenforced. Loading takes one
// beat per cycle. The schedule then emits one master beat per dispatch; tlast
// marks the final one, which also carries both averages. Each dispatch sweeps
// the process memory through its single read port, then does the arithmetic and
// waits on the 38-step serial divider for the weighted turnaround; the final
// dispatch runs the divider twice more. While the schedule runs the slave side
// is not ready; a stalled master beat is held until taken. Reset clears the
// count, flags, sums and the policy to FCFS; the memory contents need no
// clearing.
`default_nettype none
module nonpreemptive_fcfs_sjf_scheduler
  import nfs_pkg::*;
#(
  parameter int unsigned MAX_PROCS = MaxProcsDef
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [0:0]          cfg_wdata_i,       // policy_mode
  input  wire logic                s_axis_tvalid_i,
  output logic                     s_axis_tready_o,
  input  wire logic [InDataW-1:0]  s_axis_tdata_i,    // arrival_time, service_time
  input  wire logic                s_axis_tlast_i,    // load_last
  output logic                     m_axis_tvalid_o,
  input  wire logic                m_axis_tready_i,
  // proc_index, start_tick, finish_tick, turnaround, weighted_turnaround,
  // avg_turnaround, avg_weighted, zero pad
  output logic [OutDataW-1:0]      m_axis_tdata_o,
  output logic                     m_axis_tlast_o     // run_last
);
  localparam int unsigned AW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int unsigned CW = $clog2(MAX_PROCS + 1);

  sched_state_e state_q, state_d;
  logic policy_q;
  logic [CW-1:0] count_q, scan_q, disp_q;
  logic [MAX_PROCS-1:0] done_q;
  logic rd_valid_q;
  logic [AW-1:0] rd_idx_q;
  logic [TickW-1:0] tick_q;
  logic [SumW-1:0] tsum_q, wsum_q;

  // Running best candidates: FCFS, SJF ready, and SJF earliest arrival.
  logic f_v_q, r_v_q, e_v_q;
  logic [AW-1:0] f_idx_q, r_idx_q, e_idx_q;
  proc_entry_t f_q, r_q, e_q;

  logic [PidxW-1:0] o_idx_q;
  logic [TickW-1:0] o_start_q, o_fin_q, o_ta_q, o_w_q, o_avgt_q, o_avgw_q;
  logic o_last_q;

  proc_entry_t wr_entry, rd_entry;
  logic load_acc, store_we;
  logic [AW-1:0] sel_idx;
  proc_entry_t sel;
  logic [TickW-1:0] c_start, c_fin, c_ta;
  logic div_start, div_done;
  logic [DivNumW-1:0] div_num;
  logic [TimeW-1:0] div_den;
  logic [TickW-1:0] div_quot;
  logic [SumW-1:0] wsum_new;

  assign load_acc = (state_q == StLoad) && s_axis_tvalid_i;
  assign store_we = load_acc && (count_q < CW'(MAX_PROCS));
  assign wr_entry = '{arr: s_axis_tdata_i[15:0], svc: s_axis_tdata_i[31:16]};

  nfs_store #(.Depth(MAX_PROCS), .AddrW(AW)) u_store (
    .clk_i  (clk_i),
    .we_i   (store_we),
    .waddr_i(count_q[AW-1:0]),
    .wdata_i(wr_entry),
    .raddr_i(scan_q[AW-1:0]),
    .rdata_o(rd_entry)
  );

  nfs_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (div_num),
    .den_i  (div_den),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  always_comb begin
    if (policy_q == PolicyFcfs) begin
      sel_idx = f_idx_q;
      sel     = f_q;
    end else if (r_v_q) begin
      sel_idx = r_idx_q;
      sel     = r_q;
    end else begin
      sel_idx = e_idx_q;
      sel     = e_q;
    end
    c_start = (tick_q > TickW'(sel.arr)) ? tick_q : TickW'(sel.arr);
    c_fin   = c_start + TickW'(sel.svc);
    c_ta    = c_fin - TickW'(sel.arr);
    wsum_new = wsum_q + SumW'(div_quot);
  end

  always_comb begin
    state_d   = state_q;
    div_start = 1'b0;
    div_num   = {{(DivNumW-TickW-8){1'b0}}, c_ta, 8'h00};
    div_den   = sel.svc;
    case (state_q)
      StLoad: if (load_acc && s_axis_tlast_i) state_d = StScan;
      StScan: if (scan_q == count_q && !rd_valid_q) state_d = StCalc;
      StCalc: begin
        div_start = 1'b1;
        state_d   = StDivW;
      end
      StDivW: begin
        if (div_done) begin
          if (disp_q == count_q - 1'b1) begin
            div_start = 1'b1;
            div_num   = {tsum_q, 8'h00};
            div_den   = TimeW'(count_q);
            state_d   = StDivT;
          end else begin
            state_d = StEmit;
          end
        end
      end
      StDivT: begin
        if (div_done) begin
          div_start = 1'b1;
          div_num   = DivNumW'(wsum_q);
          div_den   = TimeW'(count_q);
          state_d   = StDivA;
        end
      end
      StDivA: if (div_done) state_d = StEmit;
      StEmit: if (m_axis_tready_i) state_d = o_last_q ? StLoad : StScan;
      default: state_d = StLoad;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StLoad;
      policy_q   <= PolicyFcfs;
      count_q    <= '0;
      scan_q     <= '0;
      disp_q     <= '0;
      done_q     <= '0;
      rd_valid_q <= 1'b0;
      tick_q     <= '0;
      tsum_q     <= '0;
      wsum_q     <= '0;
      f_v_q      <= 1'b0;
      r_v_q      <= 1'b0;
      e_v_q      <= 1'b0;
      o_last_q   <= 1'b0;
    end else begin
      state_q    <= state_d;
      rd_valid_q <= 1'b0;
      if (cfg_we_i) policy_q <= cfg_wdata_i[0];
      case (state_q)
        StLoad: begin
          if (store_we) count_q <= count_q + 1'b1;
          scan_q <= '0;
        end
        StScan: begin
          if (scan_q != count_q) begin
            scan_q     <= scan_q + 1'b1;
            rd_valid_q <= 1'b1;
          end
          if (rd_valid_q && !done_q[rd_idx_q]) begin
            if (!f_v_q || rd_entry.arr <= f_q.arr) f_v_q <= 1'b1;
            if (TickW'(rd_entry.arr) <= tick_q && (!r_v_q || rd_entry.svc < r_q.svc))
              r_v_q <= 1'b1;
            if (!e_v_q || rd_entry.arr < e_q.arr ||
                (rd_entry.arr == e_q.arr && rd_entry.svc < e_q.svc))
              e_v_q <= 1'b1;
          end
        end
        StCalc: begin
          done_q[sel_idx] <= 1'b1;
          tick_q <= c_fin;
          tsum_q <= tsum_q + SumW'(c_ta);
        end
        StDivW: begin
          if (div_done) begin
            wsum_q   <= wsum_new;
            o_last_q <= (disp_q == count_q - 1'b1);
            disp_q   <= disp_q + 1'b1;
          end
        end
        StEmit: begin
          if (m_axis_tready_i) begin
            scan_q <= '0;
            f_v_q  <= 1'b0;
            r_v_q  <= 1'b0;
            e_v_q  <= 1'b0;
            if (o_last_q) begin
              count_q  <= '0;
              disp_q   <= '0;
              done_q   <= '0;
              tick_q   <= '0;
              tsum_q   <= '0;
              wsum_q   <= '0;
              o_last_q <= 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Candidate payloads and result fields need no reset.
  always_ff @(posedge clk_i) begin
    rd_idx_q <= scan_q[AW-1:0];
    if (state_q == StScan && rd_valid_q && !done_q[rd_idx_q]) begin
      if (!f_v_q || rd_entry.arr <= f_q.arr) begin
        f_idx_q <= rd_idx_q;
        f_q     <= rd_entry;
      end
      if (TickW'(rd_entry.arr) <= tick_q && (!r_v_q || rd_entry.svc < r_q.svc)) begin
        r_idx_q <= rd_idx_q;
        r_q     <= rd_entry;
      end
      if (!e_v_q || rd_entry.arr < e_q.arr ||
          (rd_entry.arr == e_q.arr && rd_entry.svc < e_q.svc)) begin
        e_idx_q <= rd_idx_q;
        e_q     <= rd_entry;
      end
    end
    if (state_q == StCalc) begin
      o_idx_q   <= PidxW'(sel_idx);
      o_start_q <= c_start;
      o_fin_q   <= c_fin;
      o_ta_q    <= c_ta;
      o_avgt_q  <= '0;
      o_avgw_q  <= '0;
    end
    if (state_q == StDivW && div_done) o_w_q <= div_quot;
    if (state_q == StDivT && div_done) o_avgt_q <= div_quot;
    if (state_q == StDivA && div_done) o_avgw_q <= div_quot;
  end

  assign s_axis_tready_o = (state_q == StLoad);
  assign m_axis_tvalid_o = (state_q == StEmit);
  assign m_axis_tlast_o  = o_last_q;
  assign m_axis_tdata_o  = {2'b00, o_avgw_q, o_avgt_q, o_w_q, o_ta_q, o_fin_q,
                            o_start_q, o_idx_q};

`ifndef NO_ASSERTIONS
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready_o && m_axis_tvalid_o))
    else $error("load and dispatch sides active together");
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MAX_PROCS))
    else $error("process count beyond table depth");
  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tready_i && m_axis_tlast_o) |=>
    (count_q == '0 && done_q == '0 && s_axis_tready_o))
    else $error("schedule state not cleared after final dispatch");
  a_disp_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    disp_q <= count_q)
    else $error("more dispatches than loaded processes");
`endif
endmodule
`default_nettype wire
